>>> design/lcr_pkg.sv
// Shared types, codes and constants of the limit counter with local reserves.
package lcr_pkg;

	localparam int unsigned NUM_AGENTS_DEF = 16;
	localparam int unsigned SLOT_BITS_DEF = 16;
	localparam logic [31:0] LIMIT_RST = 32'd33554432;
	localparam logic [4:0] ONLINE_RST = 5'd16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_AGENTS = 1'd1;

	localparam logic [2:0] REQ_ADD = 3'd0;
	localparam logic [2:0] REQ_SUB = 3'd1;
	localparam logic [2:0] REQ_READ = 3'd2;
	localparam logic [2:0] REQ_REG = 3'd3;
	localparam logic [2:0] REQ_UNREG = 3'd4;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] agent;
		logic [31:0] amount;
	} in_t;

	typedef struct packed {
		logic ok;
		logic [31:0] total;
	} out_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FAST,
		OP_FOLD,
		OP_WALK_FOLD,
		OP_WALK_SUM,
		OP_APPLY,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_REFILL,
		OP_REG,
		OP_UNREG,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
		logic ok;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic agent_ok;
		logic fast_ok;
		logic short_f;
		logic reserve_zero;
		logic walk_last;
		logic div_last;
	} stat_t;

endpackage

>>> design/lcr_dp.sv
// Datapath: agent slots, shared count and reserve, divider, output register.
module lcr_dp #(
	parameter int unsigned NUM_AGENTS = lcr_pkg::NUM_AGENTS_DEF,
	parameter int unsigned SLOT_BITS = lcr_pkg::SLOT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  lcr_pkg::in_t in_word,
	input  logic cfg_we,
	input  logic [lcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  lcr_pkg::cmd_t cmd,
	output lcr_pkg::stat_t stat,
	output lcr_pkg::out_t out_word
);
	localparam int unsigned IW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
	localparam logic [32:0] SLOT_MAX = (33'd1 << SLOT_BITS) - 33'd1;

	logic [SLOT_BITS-1:0] cnt_q [NUM_AGENTS];
	logic [SLOT_BITS-1:0] cap_q [NUM_AGENTS];
	logic [NUM_AGENTS-1:0] reg_q;
	logic [31:0] sc_q, sr_q, limit_q;
	logic [4:0] online_q;
	lcr_pkg::in_t req_q;
	logic [IW-1:0] idx_q;
	logic [31:0] acc_q, quo_q, dvd_q;
	logic [4:0] rem_q, dcnt_q;
	lcr_pkg::out_t out_q;

	logic walking;
	logic [IW-1:0] agent_a, addr;
	logic [31:0] rd_cnt, rd_cap, hr, divisor, cap_n, half, take, slot_max32;
	logic [32:0] used, fsum, asum;
	logic [5:0] rtry;

	assign walking = (cmd.op == lcr_pkg::OP_WALK_FOLD) || (cmd.op == lcr_pkg::OP_WALK_SUM);
	assign agent_a = IW'(req_q.agent);
	assign addr = walking ? idx_q : agent_a;
	assign rd_cnt = 32'(cnt_q[addr]);
	assign rd_cap = 32'(cap_q[addr]);
	assign slot_max32 = 32'(SLOT_MAX);

	assign used = 33'(sc_q) + 33'(sr_q);
	assign hr = (used >= 33'(limit_q)) ? 32'd0 : 32'(33'(limit_q) - used);
	assign fsum = 33'(rd_cnt) + 33'(req_q.amount);
	assign asum = 33'(acc_q) + 33'(rd_cnt);
	assign divisor = (online_q == 5'd0) ? 32'd1 : 32'(online_q);
	assign rtry = {rem_q, dvd_q[31]} - 6'(divisor);
	assign cap_n = (quo_q > slot_max32) ? slot_max32 : quo_q;
	assign half = cap_n >> 1;
	assign take = (half > sc_q) ? sc_q : half;

	always_comb begin
		stat.req = req_q.req_type;
		stat.agent_ok = 32'(req_q.agent) < NUM_AGENTS;
		stat.reserve_zero = (sr_q == 32'd0);
		stat.walk_last = (32'(idx_q) == NUM_AGENTS - 1);
		stat.div_last = (dcnt_q == 5'd0);
		if (req_q.req_type == lcr_pkg::REQ_ADD) begin
			stat.fast_ok = (33'(req_q.amount) <= SLOT_MAX) && (fsum <= 33'(rd_cap));
			stat.short_f = hr < req_q.amount;
		end else begin
			stat.fast_ok = req_q.amount <= rd_cnt;
			stat.short_f = sc_q < req_q.amount;
		end
	end

	assign out_word = out_q;

	// config registers and shared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lcr_pkg::LIMIT_RST;
			online_q <= lcr_pkg::ONLINE_RST;
			sc_q <= '0;
			sr_q <= '0;
			reg_q <= '0;
			for (int i = 0; i < NUM_AGENTS; i++) begin
				cnt_q[i] <= '0;
				cap_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lcr_pkg::CFG_GLOBAL_LIMIT: limit_q <= cfg_data;
					lcr_pkg::CFG_ONLINE_AGENTS: online_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			case (cmd.op)
				lcr_pkg::OP_FAST: begin
					if (req_q.req_type == lcr_pkg::REQ_ADD)
						cnt_q[addr] <= SLOT_BITS'(fsum);
					else
						cnt_q[addr] <= SLOT_BITS'(rd_cnt - req_q.amount);
				end
				lcr_pkg::OP_FOLD, lcr_pkg::OP_UNREG: begin
					sc_q <= sc_q + rd_cnt;
					sr_q <= sr_q - rd_cap;
					cnt_q[addr] <= '0;
					cap_q[addr] <= '0;
					if (cmd.op == lcr_pkg::OP_UNREG) reg_q[addr] <= 1'b0;
				end
				lcr_pkg::OP_WALK_FOLD: begin
					if (reg_q[addr]) begin
						sc_q <= sc_q + rd_cnt;
						sr_q <= sr_q - rd_cap;
						cnt_q[addr] <= '0;
						cap_q[addr] <= '0;
					end
				end
				lcr_pkg::OP_APPLY: begin
					if (req_q.req_type == lcr_pkg::REQ_ADD) sc_q <= sc_q + req_q.amount;
					else sc_q <= sc_q - req_q.amount;
				end
				lcr_pkg::OP_REFILL: begin
					sr_q <= sr_q + cap_n;
					sc_q <= sc_q - take;
					cnt_q[addr] <= SLOT_BITS'(take);
					cap_q[addr] <= SLOT_BITS'(cap_n);
				end
				lcr_pkg::OP_REG: reg_q[addr] <= 1'b1;
				default: ;
			endcase
		end
	end

	// request, walk index, sum accumulator, divider, result
	always_ff @(posedge clk) begin
		case (cmd.op)
			lcr_pkg::OP_LOAD: begin
				req_q <= in_word;
				idx_q <= '0;
				acc_q <= sc_q;
			end
			lcr_pkg::OP_WALK_FOLD: idx_q <= idx_q + IW'(1);
			lcr_pkg::OP_WALK_SUM: begin
				idx_q <= idx_q + IW'(1);
				if (reg_q[addr]) acc_q <= asum[32] ? 32'hFFFF_FFFF : asum[31:0];
			end
			lcr_pkg::OP_DIV_START: begin
				dvd_q <= hr;
				rem_q <= '0;
				dcnt_q <= 5'd31;
			end
			lcr_pkg::OP_DIV_STEP: begin
				// one quotient bit a cycle, restoring
				dvd_q <= dvd_q << 1;
				dcnt_q <= dcnt_q - 5'd1;
				if (!rtry[5]) begin
					rem_q <= rtry[4:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[3:0], dvd_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			lcr_pkg::OP_RESULT: begin
				out_q.ok <= cmd.ok;
				out_q.total <= (cmd.ok && req_q.req_type == lcr_pkg::REQ_READ) ? acc_q : 32'd0;
			end
			default: ;
		endcase
	end

endmodule

>>> design/lcr_ctrl.sv
// Controller: sequences each request through the datapath and drives handshakes.
module lcr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  lcr_pkg::stat_t stat,
	output lcr_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_SUM, S_CHECK, S_FLUSH, S_RECHECK,
		S_DIVS, S_DIV, S_REFILL, S_FIN
	} state_t;

	state_t state_q, state_n;
	logic ok_q, ok_n, out_valid_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		ok_n = ok_q;
		cmd.op = lcr_pkg::OP_NONE;
		cmd.ok = ok_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op = lcr_pkg::OP_LOAD;
				state_n = S_DECIDE;
			end
			S_DECIDE: begin
				ok_n = 1'b1;
				state_n = S_FIN;
				if (!stat.agent_ok) begin
					ok_n = 1'b0;
				end else begin
					unique case (stat.req)
						lcr_pkg::REQ_ADD, lcr_pkg::REQ_SUB: begin
							if (stat.fast_ok) begin
								cmd.op = lcr_pkg::OP_FAST;
							end else begin
								cmd.op = lcr_pkg::OP_FOLD;
								state_n = S_CHECK;
							end
						end
						lcr_pkg::REQ_READ: state_n = S_SUM;
						lcr_pkg::REQ_REG: cmd.op = lcr_pkg::OP_REG;
						lcr_pkg::REQ_UNREG: cmd.op = lcr_pkg::OP_UNREG;
						default: ok_n = 1'b0;
					endcase
				end
			end
			S_SUM: begin
				cmd.op = lcr_pkg::OP_WALK_SUM;
				if (stat.walk_last) state_n = S_FIN;
			end
			S_CHECK: begin
				if (!stat.short_f) begin
					cmd.op = lcr_pkg::OP_APPLY;
					state_n = S_DIVS;
				end else if (stat.reserve_zero) begin
					ok_n = 1'b0;
					state_n = S_FIN;
				end else begin
					state_n = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.op = lcr_pkg::OP_WALK_FOLD;
				if (stat.walk_last) state_n = S_RECHECK;
			end
			S_RECHECK: begin
				if (stat.short_f) begin
					ok_n = 1'b0;
					state_n = S_FIN;
				end else begin
					cmd.op = lcr_pkg::OP_APPLY;
					state_n = S_DIVS;
				end
			end
			S_DIVS: begin
				cmd.op = lcr_pkg::OP_DIV_START;
				state_n = S_DIV;
			end
			S_DIV: begin
				cmd.op = lcr_pkg::OP_DIV_STEP;
				if (stat.div_last) state_n = S_REFILL;
			end
			S_REFILL: begin
				cmd.op = lcr_pkg::OP_REFILL;
				state_n = S_FIN;
			end
			S_FIN: if (!out_valid_q || !out_stall) begin
				cmd.op = lcr_pkg::OP_RESULT;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ok_q <= ok_n;
			if (cmd.op == lcr_pkg::OP_RESULT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECIDE))
		else $error("accepted word did not start decode");
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && stat.walk_last) |=> (state_q == S_RECHECK))
		else $error("flush walk did not end in recheck");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && stat.div_last) |=> (state_q == S_REFILL))
		else $error("divider did not hand over to refill");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lcr_pkg::OP_RESULT) |=> (out_valid && state_q == S_IDLE))
		else $error("result word not presented");

endmodule

>>> design/limit_counter_with_local_reserves_core.sv
// Top level of the limit counter with per-agent local reserves.
// Paths from accepted word to result word: a local-slot add/sub, register, unregister or
// rejected word goes straight to the result; a read walks every agent slot; a slow add/sub
// folds its slot, may walk a flush, then applies and refills (32-step divider) or is refused.
// One request in flight: the next word is taken at the edge after the result word issues.
// Reset (arst_n low) clears all slots, shared count and reserve; limit 2^25, 16 agents.
module limit_counter_with_local_reserves_core #(
	parameter int unsigned NUM_AGENTS = lcr_pkg::NUM_AGENTS_DEF,
	parameter int unsigned SLOT_BITS = lcr_pkg::SLOT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lcr_pkg::in_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output lcr_pkg::out_t out_word,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	lcr_pkg::cmd_t cmd;
	lcr_pkg::stat_t stat;

	// configuration words are always taken
	assign cfg_ready = 1'b1;

	lcr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	lcr_dp #(.NUM_AGENTS(NUM_AGENTS), .SLOT_BITS(SLOT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_word(in_word),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat), .out_word(out_word)
	);

endmodule
